// ----- sv/bounded_deque_with_remove_unit_defines.svh -----
// Assertion macros used by the deque controller.
`ifndef BOUNDED_DEQUE_WITH_REMOVE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define BDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define BDR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BDR_ASSERT(label, prop, msg)
`define BDR_NEVER(label, cond, msg)
`endif

`endif

// ----- sv/bdr_pkg.sv -----
package bdr_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int DATA_W    = 32;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_SCAN
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_WRITE,
    OP_CLOSE,
    OP_LOAD,
    OP_SHIFT
  } cell_op_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  // What the controller sees of the front cell
  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    logic signed [DATA_W-1:0]  line;
    logic                      match;
  } cell_view_t;

endpackage

// ----- sv/bdr_cell.sv -----
module bdr_cell import bdr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0]  idx,
  input  logic signed [DATA_W-1:0]  left_data,
  input  logic signed [DATA_W-1:0]  right_data,
  input  logic signed [DATA_W-1:0]  right_line,
  input  logic                      right_match,
  output logic signed [DATA_W-1:0]  data,
  output logic signed [DATA_W-1:0]  line,
  output logic                      match
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // Entry storage plus the readout line and match line toward the front
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_PUSH_FRONT: begin
        // first cell takes the new item, the rest move one place back
        data <= (MY_IDX == '0) ? ctl.value : left_data;
      end
      OP_WRITE: begin
        if (idx == MY_IDX) begin
          data <= ctl.value;
        end
      end
      OP_CLOSE: begin
        // close the gap: cells at and after the index take their neighbor
        if (MY_IDX >= idx) begin
          data <= right_data;
        end
      end
      OP_LOAD: begin
        line  <= data;
        match <= (data == ctl.value);
      end
      OP_SHIFT: begin
        line  <= right_line;
        match <= right_match;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/bdr_ctrl.sv -----
`include "bounded_deque_with_remove_unit_defines.svh"

module bdr_ctrl import bdr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        command,
  input  logic signed [DATA_W-1:0]          value_in,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [DATA_W-1:0]          value_out,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count,
  input  cell_view_t                        head,
  output cell_ctl_t                         ctl,
  output logic [$clog2(DEPTH)-1:0]          idx
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ctrl_state_t              state, state_next;
  logic [IW-1:0]            k, k_next;
  logic [CW-1:0]            count, count_next;
  logic signed [DATA_W-1:0] key, key_next;

  logic                     res_v;
  logic [1:0]               res_status;
  logic signed [DATA_W-1:0] res_value;
  logic                     is_full, is_empty, at_last;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign at_last  = (CW'(k) == count - CW'(1));
  assign busy     = (state != S_IDLE);

  // State, position, count and done registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      count <= count_next;
      done  <= res_v;
    end
  end

  // Search key and result payload
  always_ff @(posedge clk) begin
    key <= key_next;
    if (res_v) begin
      status      <= res_status;
      value_out   <= res_value;
      entry_count <= count_next;
    end
  end

  // Next state, cell commands and result
  always_comb begin
    state_next = state;
    k_next     = k;
    count_next = count;
    key_next   = key;
    ctl.op     = OP_HOLD;
    ctl.value  = value_in;
    idx        = k;
    res_v      = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_PUSH_FRONT: begin
              res_v = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ctl.op     = OP_PUSH_FRONT;
                count_next = count + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              res_v = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ctl.op     = OP_WRITE;
                idx        = count[IW-1:0];
                count_next = count + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              res_v = 1'b1;
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.op     = OP_CLOSE;
                idx        = '0;
                res_value  = head.data;
                count_next = count - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                res_v      = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ctl.op     = OP_LOAD;
                k_next     = '0;
                state_next = S_DRAIN;
              end
            end
            CMD_REMOVE: begin
              if (is_empty) begin
                res_v      = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ctl.op     = OP_LOAD;
                key_next   = value_in;
                k_next     = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              res_v = 1'b1;
            end
          endcase
        end
      end
      S_DRAIN: begin
        // readout line brings entry k to the front cell
        if (at_last) begin
          res_v      = 1'b1;
          res_value  = head.line;
          count_next = count - CW'(1);
          state_next = S_IDLE;
        end else begin
          ctl.op = OP_SHIFT;
          k_next = k + IW'(1);
        end
      end
      S_SCAN: begin
        ctl.value = key;
        if (head.match) begin
          ctl.op     = OP_CLOSE;
          res_v      = 1'b1;
          res_value  = key;
          count_next = count - CW'(1);
          state_next = S_IDLE;
        end else if (at_last) begin
          res_v      = 1'b1;
          res_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          ctl.op = OP_SHIFT;
          k_next = k + IW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BDR_NEVER(a_count_range, count > CW'(DEPTH), "entry count above depth")
  `BDR_NEVER(a_no_result_while_busy, busy && done, "result shown while a walk runs")
  `BDR_ASSERT(a_walk_in_range, (state != S_IDLE) |-> (CW'(k) < count), "walk past held entries")
  `BDR_ASSERT(a_zero_on_fail, (done && status != ST_OK) |-> (value_out == '0), "value on failed item")
  `BDR_ASSERT(a_push_grows, (!busy && start && command == CMD_PUSH_BACK && !is_full) |=> (done && status == ST_OK && count == $past(count) + CW'(1)), "push did not grow count")

endmodule

// ----- sv/bounded_deque_with_remove_unit.sv -----
// Bounded double-ended queue of signed 32-bit items with remove by value.
// Command channel: an item (command, value_in) is taken at a rising edge with
// start high and busy low. Result channel: done is high for one cycle with
// status, value_out and entry_count; the receiver cannot hold it off.
// Storage is a row of DEPTH cells kept in list order, front in the first cell.
// Push front, push back and pop front: the result follows in the next cycle
// and busy stays low, so a new item may enter every cycle.
// Pop back loads a readout line that shifts one cell a cycle toward the front:
// busy until the last entry reaches the front cell, which gives the result.
// Remove loads a match bit in every cell and shifts those bits to the front
// one cell a cycle; the walk ends at the first match counted from the front,
// or at the last entry when nothing matches, and the cells behind the match
// close the gap in the cycle that registers the result.
// Reset empties the list and clears done; cell contents are not cleared.
module bounded_deque_with_remove_unit import bdr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    command,
  input  logic signed [DATA_W-1:0]      value_in,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      value_out,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count
);

  localparam int IW = $clog2(DEPTH);

  cell_ctl_t                ctl;
  cell_view_t               head;
  logic [IW-1:0]            idx;
  logic signed [DATA_W-1:0] cell_data  [DEPTH];
  logic signed [DATA_W-1:0] cell_line  [DEPTH];
  logic                     cell_match [DEPTH];

  bdr_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count),
    .head        (head),
    .ctl         (ctl),
    .idx         (idx)
  );

  // Front cell feeds the controller
  assign head = '{data: cell_data[0], line: cell_line[0], match: cell_match[0]};

  // Row of cells, each linked to both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d, right_l;
    logic                     right_m;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner
      assign left_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
      assign right_l = '0;
      assign right_m = 1'b0;
    end else begin : g_body
      assign right_d = cell_data[g+1];
      assign right_l = cell_line[g+1];
      assign right_m = cell_match[g+1];
    end

    bdr_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (idx),
      .left_data   (left_d),
      .right_data  (right_d),
      .right_line  (right_l),
      .right_match (right_m),
      .data        (cell_data[g]),
      .line        (cell_line[g]),
      .match       (cell_match[g])
    );
  end

endmodule

// ----- bench/bdr_checker.sv -----
`timescale 1ns / 1ps

// Watch the command and result channels of the deque, predict every result
// from a shadow copy of the list and compare it with what the block returns.
module bdr_checker import bdr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [2:0]                 command,
  input  logic signed [DATA_W-1:0]   value_in,
  input  logic                       done,
  input  logic [1:0]                 status,
  input  logic signed [DATA_W-1:0]   value_out,
  input  logic [$clog2(DEPTH+1)-1:0] entry_count,
  output int                         fail_count,
  output int                         pending,
  output int                         checked,
  output int                         full_seen,
  output int                         empty_seen,
  output int                         missing_seen
);

  localparam int CW = $clog2(DEPTH+1);

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value;
    logic [CW-1:0]            count;
  } outcome_t;

  // Shadow list, front at index 0, and the results still owed by the block
  logic signed [DATA_W-1:0] shadow_list [$];
  outcome_t                 owed_results [$];

  // Apply one command to the shadow list and return the result it must give
  function automatic outcome_t apply_command(input logic [2:0] cmd,
                                             input logic signed [DATA_W-1:0] val);
    outcome_t res;
    int       hit;
    int       idx;
    res.status = ST_OK;
    res.value  = '0;
    hit        = -1;
    idx        = 0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_list.size() >= DEPTH) res.status = ST_FULL;
        else if (cmd == CMD_PUSH_FRONT) shadow_list.push_front(val);
        else shadow_list.push_back(val);
      end
      CMD_POP_FRONT: begin
        if (shadow_list.size() == 0) res.status = ST_EMPTY;
        else res.value = shadow_list.pop_front();
      end
      CMD_POP_BACK: begin
        if (shadow_list.size() == 0) res.status = ST_EMPTY;
        else res.value = shadow_list.pop_back();
      end
      CMD_REMOVE: begin
        if (shadow_list.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // find the first match counted from the front
          while (hit < 0 && idx < shadow_list.size()) begin
            if (shadow_list[idx] == val) hit = idx;
            idx++;
          end
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.value = shadow_list[hit];
            shadow_list.delete(hit);
          end
        end
      end
      default: ;
    endcase
    res.count = CW'(shadow_list.size());
    return res;
  endfunction

  // Count a failure, report only the first few
  task automatic flag_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  // Check the result first, then take the item accepted at this edge
  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      shadow_list.delete();
      owed_results.delete();
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          flag_failure($sformatf("result with no item pending: status %0d value %0d count %0d",
                                 status, value_out, entry_count));
        end else begin
          want = owed_results.pop_front();
          checked++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_EMPTY) empty_seen++;
          if (want.status == ST_NOT_FOUND) missing_seen++;
          if (status !== want.status || value_out !== want.value ||
              entry_count !== want.count)
            flag_failure($sformatf({"mismatch: expected status %0d value %0d count %0d,",
                                    " got status %0d value %0d count %0d"},
                                   want.status, want.value, want.count,
                                   status, value_out, entry_count));
        end
      end
      if (start && !busy) owed_results.push_back(apply_command(command, value_in));
    end
    pending = owed_results.size();
  end

endmodule

// ----- bench/tb_bounded_deque_with_remove_unit.sv -----
`timescale 1ns / 1ps

module tb_bounded_deque_with_remove_unit import bdr_pkg::*;;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CW          = $clog2(DEPTH+1);
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = DEPTH + 20;

  typedef enum logic [1:0] {
    MIX_SMALL,
    MIX_FILL,
    MIX_DRAIN
  } mix_t;

  logic                     clk;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic [2:0]               command  = CMD_PUSH_FRONT;
  logic signed [DATA_W-1:0] value_in = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] value_out;
  logic [CW-1:0]            entry_count;

  int idle_pct = 0;
  int cycles   = 0;
  int fail_count, pending, checked, full_seen, empty_seen, missing_seen;

  // Values that repeat often so that removes find matches and duplicates
  logic signed [DATA_W-1:0] hot_values [8];

  bounded_deque_with_remove_unit #(.DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .value_in    (value_in),
    .done        (done),
    .status      (status),
    .value_out   (value_out),
    .entry_count (entry_count)
  );

  bdr_checker #(.DEPTH(DEPTH)) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .value_in     (value_in),
    .done         (done),
    .status       (status),
    .value_out    (value_out),
    .entry_count  (entry_count),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .full_seen    (full_seen),
    .empty_seen   (empty_seen),
    .missing_seen (missing_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle at random, then hold the item until the block takes it
  task automatic send_item(input logic [2:0] cmd, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    command  <= cmd;
    value_in <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_command(input mix_t mix);
    logic [2:0] cmd;
    int         roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  cmd = (roll < 50) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      MIX_DRAIN: begin
        if (roll < 50) cmd = CMD_POP_FRONT;
        else if (roll < 75) cmd = CMD_POP_BACK;
        else cmd = CMD_REMOVE;
      end
      default: begin
        if (roll < 18) cmd = CMD_PUSH_FRONT;
        else if (roll < 35) cmd = CMD_PUSH_BACK;
        else if (roll < 53) cmd = CMD_POP_FRONT;
        else if (roll < 70) cmd = CMD_POP_BACK;
        else cmd = CMD_REMOVE;
      end
    endcase
    return cmd;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(1) == 0) return hot_values[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic run_mix(input mix_t mix, input int n);
    repeat (n) send_item(pick_command(mix), pick_value());
  endtask

  initial begin : stimulus
    hot_values = '{32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sd7, 32'sd42, -32'sd42};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extreme values, duplicates, removes at each end
    idle_pct = 37;
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_POP_BACK, 32'sd0);
    send_item(CMD_REMOVE, 32'sd0);
    send_item(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_item(CMD_PUSH_BACK, 32'sd0);
    send_item(CMD_PUSH_FRONT, -32'sd1);
    send_item(CMD_PUSH_BACK, 32'sd5);
    send_item(CMD_PUSH_BACK, 32'sd0);
    send_item(CMD_REMOVE, 32'sd0);
    send_item(CMD_REMOVE, 32'sd12345);
    send_item(CMD_REMOVE, -32'sd1);
    send_item(CMD_REMOVE, 32'sd0);
    send_item(CMD_POP_BACK, 32'sd0);
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_REMOVE, 32'sh7FFF_FFFF);
    send_item(CMD_PUSH_FRONT, 32'sh5555_5555);
    send_item(CMD_PUSH_BACK, 32'shAAAA_AAAA);
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_POP_BACK, 32'sd0);

    // Random: small lists with sparse gaps
    run_mix(MIX_SMALL, 600);

    // Fill past full and drain with heavy gaps
    idle_pct = 61;
    run_mix(MIX_FILL, 265);
    run_mix(MIX_DRAIN, 285);

    // Same again back to back, then small lists
    idle_pct = 0;
    run_mix(MIX_FILL, 265);
    run_mix(MIX_DRAIN, 285);
    run_mix(MIX_SMALL, 150);
    start <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results over three sender gap settings, filling and draining twice;",
             checked);
    $display("%0d pushes rejected when full, %0d commands on an empty list, %0d removes missed.",
             full_seen, empty_seen, missing_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bdr_pkg.sv
sv/bdr_cell.sv
sv/bdr_ctrl.sv
sv/bounded_deque_with_remove_unit.sv
bench/bdr_checker.sv
bench/tb_bounded_deque_with_remove_unit.sv
